// ===== hw/rtl/dsfe_pkg.sv =====
// Package for the decoder slot farthest eviction unit.
// Holds table sizes, command and status codes and the slot entry type.
// No dependencies.
`timescale 1ns / 1ps

package dsfe_pkg;

  localparam int SLOTS = 4;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam int CLIP_W = 16;
  localparam int TRACK_W = 8;
  localparam int TIME_W = 32;
  localparam int OCC_W = 7;
  localparam int DIST_W = TIME_W + 1;

  typedef enum logic [1:0] {
    CMD_REQUEST  = 2'd0,
    CMD_RELEASE  = 2'd1,
    CMD_PLAYHEAD = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_REFRESHED = 3'd0,
    ST_APPENDED  = 3'd1,
    ST_EVICTED   = 3'd2,
    ST_DENIED    = 3'd3,
    ST_RELEASED  = 3'd4,
    ST_NOTFOUND  = 3'd5,
    ST_DONE      = 3'd6
  } status_t;

  typedef struct packed {
    logic [CLIP_W-1:0]  clip;
    logic [TRACK_W-1:0] track;
    logic [TIME_W-1:0]  start;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hw/rtl/dsfe_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dsfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/decoder_slot_farthest_eviction_unit.sv =====
// Top level of the decoder slot farthest eviction unit.
// Depends on dsfe_pkg and dsfe_ram.
//
//   channel | ports                                         | direction
//   in      | in_valid/in_ready, command, clip_id, track,   | into block
//           | time_value                                    |
//   out     | out_valid/out_ready, status, evicted valid and| out of block
//           | clip, occupancy                               |
//
// Request and release scan the occupied entries of the slot RAM, which has registered read
// data, drain the last read, commit in S_FINISH and load the output in S_OUT; on an empty
// table the scan ends at once. Set playhead and clear go straight to S_FINISH and S_OUT.
// One item is in work at a time, and the next beat is taken in the cycle after the result
// is loaded.
// Reset empties the table and zeroes the playhead; the RAM is not cleared.
// A finished beat waits in the output register while the next beat is taken; a new result
// waits in the output stage until the previous one is accepted.
`timescale 1ns / 1ps

module decoder_slot_farthest_eviction_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_command,
  input  logic [15:0]                 in_clip_id,
  input  logic [7:0]                  in_track_number,
  input  logic signed [31:0]          in_time_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_status,
  output logic                        out_evicted_valid,
  output logic [15:0]                 out_evicted_clip,
  output logic [6:0]                  out_occupancy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_OUT
  } state_t;

  state_t state_r;

  dsfe_pkg::cmd_t                    cmd_r;
  logic [dsfe_pkg::CLIP_W-1:0]       id_r;
  logic [dsfe_pkg::TRACK_W-1:0]      trk_r;
  logic [dsfe_pkg::TIME_W-1:0]       time_r;
  logic [dsfe_pkg::TIME_W-1:0]       playhead_r;
  logic [dsfe_pkg::CNT_W-1:0]        cnt_r;
  logic [dsfe_pkg::CNT_W-1:0]        rd_idx_r;
  logic                              pend_r;
  logic [dsfe_pkg::IDX_W-1:0]        pend_idx_r;
  logic                              hit_r;
  logic [dsfe_pkg::IDX_W-1:0]        hit_idx_r;
  logic                              found_r;
  logic [dsfe_pkg::IDX_W-1:0]        best_idx_r;
  logic [dsfe_pkg::DIST_W-1:0]       best_d_r;
  logic [dsfe_pkg::CLIP_W-1:0]       best_clip_r;

  dsfe_pkg::status_t                 res_status_r;
  logic                              res_ev_r;
  logic [dsfe_pkg::CLIP_W-1:0]       res_clip_r;

  logic                              out_valid_r;
  dsfe_pkg::status_t                 out_status_r;
  logic                              out_ev_r;
  logic [dsfe_pkg::CLIP_W-1:0]       out_clip_r;
  logic [dsfe_pkg::OCC_W-1:0]        out_occ_r;

  logic                              ram_we;
  logic [dsfe_pkg::IDX_W-1:0]        ram_waddr;
  dsfe_pkg::entry_t                  ram_wdata;
  logic [dsfe_pkg::ENTRY_W-1:0]      ram_rdata;
  dsfe_pkg::entry_t                  rd_ent;
  dsfe_pkg::entry_t                  new_ent;

  logic signed [dsfe_pkg::DIST_W-1:0] diff_fwd;
  logic signed [dsfe_pkg::DIST_W-1:0] diff_rev;
  logic [dsfe_pkg::DIST_W-1:0]        dist_cur;
  logic                               full;
  logic                               accept;
  logic                               evict;
  logic                               out_load;

  assign in_ready = (state_r == S_IDLE);
  assign accept = in_valid && in_ready;
  assign full = (cnt_r >= dsfe_pkg::CNT_W'(dsfe_pkg::SLOTS));
  assign evict = (cmd_r == dsfe_pkg::CMD_REQUEST) && !hit_r && full && found_r;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  assign rd_ent = dsfe_pkg::entry_t'(ram_rdata);
  assign new_ent = '{clip: id_r, track: trk_r, start: time_r};

  assign diff_fwd = {rd_ent.start[dsfe_pkg::TIME_W-1], rd_ent.start}
                  - {playhead_r[dsfe_pkg::TIME_W-1], playhead_r};
  assign diff_rev = {playhead_r[dsfe_pkg::TIME_W-1], playhead_r}
                  - {rd_ent.start[dsfe_pkg::TIME_W-1], rd_ent.start};
  assign dist_cur = diff_fwd[dsfe_pkg::DIST_W-1] ? diff_rev : diff_fwd;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = pend_idx_r - dsfe_pkg::IDX_W'(1);
    ram_wdata = rd_ent;
    if (state_r == S_SCAN && pend_r && cmd_r == dsfe_pkg::CMD_RELEASE && hit_r) begin
      ram_we = 1'b1;
    end else if (state_r == S_FINISH && cmd_r == dsfe_pkg::CMD_REQUEST) begin
      ram_wdata = new_ent;
      if (hit_r) begin
        ram_we = 1'b1;
        ram_waddr = hit_idx_r;
      end else if (!full) begin
        ram_we = 1'b1;
        ram_waddr = cnt_r[dsfe_pkg::IDX_W-1:0];
      end else if (found_r) begin
        ram_we = 1'b1;
        ram_waddr = best_idx_r;
      end
    end
  end

  dsfe_ram #(
    .WIDTH(dsfe_pkg::ENTRY_W),
    .DEPTH(dsfe_pkg::SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_idx_r[dsfe_pkg::IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      playhead_r <= '0;
      out_valid_r <= 1'b0;
      pend_r <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r <= dsfe_pkg::cmd_t'(in_command);
            id_r <= in_clip_id;
            trk_r <= in_track_number;
            time_r <= in_time_value;
            hit_r <= 1'b0;
            found_r <= 1'b0;
            rd_idx_r <= '0;
            pend_r <= 1'b0;
            if (in_command == dsfe_pkg::CMD_REQUEST || in_command == dsfe_pkg::CMD_RELEASE) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          if (rd_idx_r < cnt_r) begin
            rd_idx_r <= rd_idx_r + dsfe_pkg::CNT_W'(1);
            pend_r <= 1'b1;
            pend_idx_r <= rd_idx_r[dsfe_pkg::IDX_W-1:0];
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              state_r <= S_FINISH;
            end
          end
          if (pend_r) begin
            if (!hit_r && rd_ent.clip == id_r) begin
              hit_r <= 1'b1;
              hit_idx_r <= pend_idx_r;
            end
            if (rd_ent.track != '0 && (!found_r || dist_cur > best_d_r)) begin
              found_r <= 1'b1;
              best_d_r <= dist_cur;
              best_idx_r <= pend_idx_r;
              best_clip_r <= rd_ent.clip;
            end
          end
        end
        S_FINISH: begin
          res_ev_r <= evict;
          res_clip_r <= evict ? best_clip_r : '0;
          case (cmd_r)
            dsfe_pkg::CMD_REQUEST: begin
              if (hit_r) begin
                res_status_r <= dsfe_pkg::ST_REFRESHED;
              end else if (!full) begin
                res_status_r <= dsfe_pkg::ST_APPENDED;
                cnt_r <= cnt_r + dsfe_pkg::CNT_W'(1);
              end else if (found_r) begin
                res_status_r <= dsfe_pkg::ST_EVICTED;
              end else begin
                res_status_r <= dsfe_pkg::ST_DENIED;
              end
            end
            dsfe_pkg::CMD_RELEASE: begin
              if (hit_r) begin
                res_status_r <= dsfe_pkg::ST_RELEASED;
                cnt_r <= cnt_r - dsfe_pkg::CNT_W'(1);
              end else begin
                res_status_r <= dsfe_pkg::ST_NOTFOUND;
              end
            end
            dsfe_pkg::CMD_PLAYHEAD: begin
              res_status_r <= dsfe_pkg::ST_DONE;
              playhead_r <= time_r;
            end
            dsfe_pkg::CMD_CLEAR: begin
              res_status_r <= dsfe_pkg::ST_DONE;
              cnt_r <= '0;
            end
            default: begin
              res_status_r <= dsfe_pkg::ST_DONE;
            end
          endcase
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_status_r <= res_status_r;
            out_ev_r <= res_ev_r;
            out_clip_r <= res_clip_r;
            out_occ_r <= dsfe_pkg::OCC_W'(cnt_r);
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_evicted_valid = out_ev_r;
  assign out_evicted_clip = out_clip_r;
  assign out_occupancy = out_occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= dsfe_pkg::CNT_W'(dsfe_pkg::SLOTS))
    else $error("Slot count exceeds the table size.");

  a_evict_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_r) |-> out_status_r == dsfe_pkg::ST_EVICTED)
    else $error("Evicted flag set without evicted status.");

  a_scan_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && ram_we) |-> (cmd_r == dsfe_pkg::CMD_RELEASE && hit_r))
    else $error("Slot RAM written during a scan that is not a release shift.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("A second beat was taken while one is in work.");

endmodule
